// ----- hw/rtl/qoi_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the QOI pixel encoder.
// No dependencies; the front, queue and back modules import it.
package qoi_pkg;

    localparam int HASH_W    = 6;
    localparam int OP_BYTES  = 5;               // longest byte group one pixel can cause
    localparam int CNT_W     = $clog2(OP_BYTES + 1);
    localparam int IDX_W     = $clog2(OP_BYTES);
    localparam int Q_DEPTH   = 4;

    localparam logic [5:0] RUN_LIMIT = 6'd62;
    localparam logic [5:0] HASH_BIAS = 6'd53;   // 11 * 255 mod 64

    localparam logic [7:0] OP_DIFF = 8'h40;
    localparam logic [7:0] OP_LUMA = 8'h80;
    localparam logic [7:0] OP_RUN  = 8'hc0;
    localparam logic [7:0] OP_RGB  = 8'hfe;

    // byte group of one pixel, bytes[0] goes out first
    typedef struct packed {
        logic [CNT_W-1:0]           count;
        logic [OP_BYTES-1:0][7:0]   bytes;
    } t_op;

endpackage

// ----- hw/rtl/qoi_front.sv -----
`timescale 1ns / 1ps
// Front end: accepts pixels, looks up the color index, picks the op and
// forms the byte group of each pixel. Depends on qoi_pkg.
module qoi_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic            i_color_mode,
    input  logic            push,
    output logic            full,
    input  logic [7:0]      i_red,
    input  logic [7:0]      i_green,
    input  logic [7:0]      i_blue,
    input  logic            i_last_pixel,
    output logic            o_op_push,
    output qoi_pkg::t_op    o_op,
    input  logic            i_op_full
);
    import qoi_pkg::*;

    localparam int INDEX_DEPTH = 1 << HASH_W;

    logic                   r_color_mode;
    logic                   r_s_valid;
    logic [7:0]             r_s_r, r_s_g, r_s_b;
    logic                   r_s_last;
    logic [HASH_W-1:0]      r_s_hash;
    logic                   r_s_fwd;
    logic [23:0]            r_s_fwd_rgb;
    logic [23:0]            r_mem_q;
    logic [23:0]            r_mem [INDEX_DEPTH];
    logic [INDEX_DEPTH-1:0] r_valid;
    logic [7:0]             r_prev_r, r_prev_g, r_prev_b;
    logic [5:0]             r_run;

    logic                   accept, b_fire;
    logic [7:0]             in_g, in_b;
    logic [HASH_W-1:0]      in_hash;
    logic [23:0]            s_rgb, idx_rgb;
    logic                   pix_eq, idx_hit, diff_ok, luma_ok, run_has;
    logic [5:0]             run_inc, n_run;
    logic [7:0]             dr, dg, db, lr, lg, lb, run_byte;
    logic [3:0][7:0]        main;
    logic [CNT_W-1:0]       main_n;

    assign o_cfg_ready = 1'b1;

    assign b_fire = r_s_valid && !i_op_full;
    assign full   = r_s_valid && i_op_full;
    assign accept = push && !full;

    // gray mode replicates the red sample
    assign in_g    = r_color_mode ? i_green : i_red;
    assign in_b    = r_color_mode ? i_blue  : i_red;
    assign in_hash = 6'd3 * i_red[5:0] + 6'd5 * in_g[5:0] + 6'd7 * in_b[5:0] + HASH_BIAS;

    assign s_rgb   = {r_s_r, r_s_g, r_s_b};
    // the pixel ahead of this one wrote its entry after our read was issued
    assign idx_rgb = r_s_fwd ? r_s_fwd_rgb : r_mem_q;
    assign idx_hit = r_valid[r_s_hash] && (idx_rgb == s_rgb);
    assign pix_eq  = (s_rgb == {r_prev_r, r_prev_g, r_prev_b});
    assign run_inc = r_run + 6'd1;

    assign dr = r_s_r - r_prev_r + 8'd2;
    assign dg = r_s_g - r_prev_g + 8'd2;
    assign db = r_s_b - r_prev_b + 8'd2;
    assign diff_ok = (dr[7:2] == 6'd0) && (dg[7:2] == 6'd0) && (db[7:2] == 6'd0);
    assign lr = dr - dg + 8'd8;
    assign lb = db - dg + 8'd8;
    assign lg = dg + 8'd30;
    assign luma_ok = (lr[7:4] == 4'd0) && (lg[7:6] == 2'd0) && (lb[7:4] == 4'd0);

    always_comb begin
        main     = '0;
        main_n   = '0;
        n_run    = '0;
        run_has  = 1'b0;
        run_byte = OP_RUN | {2'b00, r_run - 6'd1};
        if (pix_eq) begin
            n_run = run_inc;
            // run closes at the limit or at the end of the image
            if (run_inc == RUN_LIMIT || r_s_last) begin
                run_has  = 1'b1;
                run_byte = OP_RUN | {2'b00, r_run};
                n_run    = '0;
            end
        end else begin
            run_has = (r_run != 6'd0);
            if (idx_hit) begin
                main[0] = {2'b00, r_s_hash};
                main_n  = CNT_W'(1);
            end else if (diff_ok) begin
                main[0] = OP_DIFF | {2'b00, dr[1:0], dg[1:0], db[1:0]};
                main_n  = CNT_W'(1);
            end else if (luma_ok) begin
                main[0] = OP_LUMA | lg;
                main[1] = {lr[3:0], lb[3:0]};
                main_n  = CNT_W'(2);
            end else begin
                main   = {r_s_b, r_s_g, r_s_r, OP_RGB};
                main_n = CNT_W'(4);
            end
        end
        o_op.bytes = run_has ? {main, run_byte} : {8'h00, main};
        o_op.count = run_has ? main_n + CNT_W'(1) : main_n;
    end

    assign o_op_push = b_fire && (o_op.count != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color_mode <= 1'b1;
            r_s_valid    <= 1'b0;
            r_prev_r     <= '0;
            r_prev_g     <= '0;
            r_prev_b     <= '0;
            r_run        <= '0;
            r_valid      <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_color_mode <= i_color_mode;
            end
            if (accept) begin
                r_s_valid <= 1'b1;
            end else if (b_fire) begin
                r_s_valid <= 1'b0;
            end
            if (b_fire) begin
                if (r_s_last) begin
                    r_prev_r <= '0;
                    r_prev_g <= '0;
                    r_prev_b <= '0;
                    r_run    <= '0;
                    r_valid  <= '0;
                end else begin
                    r_prev_r          <= r_s_r;
                    r_prev_g          <= r_s_g;
                    r_prev_b          <= r_s_b;
                    r_run             <= n_run;
                    r_valid[r_s_hash] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s_r       <= i_red;
            r_s_g       <= in_g;
            r_s_b       <= in_b;
            r_s_last    <= i_last_pixel;
            r_s_hash    <= in_hash;
            r_s_fwd     <= b_fire && !r_s_last && (in_hash == r_s_hash);
            r_s_fwd_rgb <= s_rgb;
        end
    end

    // color index, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (b_fire && !r_s_last) begin
            r_mem[r_s_hash] <= s_rgb;
        end
        if (accept) begin
            r_mem_q <= r_mem[in_hash];
        end
    end

endmodule

// ----- hw/rtl/qoi_fifo.sv -----
`timescale 1ns / 1ps
// Short queue of byte groups between the front and back ends.
// Depends on qoi_pkg.
module qoi_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  qoi_pkg::t_op    i_data,
    output logic            o_full,
    input  logic            i_pop,
    output qoi_pkg::t_op    o_data,
    output logic            o_empty
);
    import qoi_pkg::*;

    localparam int PTR_W = $clog2(Q_DEPTH);

    t_op              r_q [Q_DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [PTR_W:0]   r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == (PTR_W + 1)'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + (PTR_W + 1)'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - (PTR_W + 1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wr] <= i_data;
        end
    end

endmodule

// ----- hw/rtl/qoi_back.sv -----
`timescale 1ns / 1ps
// Back end: unpacks one byte group at a time onto the result port.
// Depends on qoi_pkg.
module qoi_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  qoi_pkg::t_op    i_op,
    input  logic            i_op_empty,
    output logic            o_op_pop,
    output logic            empty,
    input  logic            pop,
    output logic [7:0]      o_out_byte,
    output logic            o_last_of_item
);
    import qoi_pkg::*;

    t_op              r_op;
    logic             r_busy;
    logic [IDX_W-1:0] r_idx;
    logic             last_byte, advance;

    assign last_byte = (CNT_W'(r_idx) == r_op.count - CNT_W'(1));
    assign advance   = !r_busy || (pop && last_byte);
    assign o_op_pop  = advance && !i_op_empty;

    assign empty          = !r_busy;
    assign o_out_byte     = r_op.bytes[r_idx];
    assign o_last_of_item = last_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else begin
            if (o_op_pop) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (r_busy && pop) begin
                if (last_byte) begin
                    r_busy <= 1'b0;
                end
                r_idx <= r_idx + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_op_pop) begin
            r_op <= i_op;
        end
    end

endmodule

// ----- hw/rtl/qoi_pixel_encoder.sv -----
`timescale 1ns / 1ps
// QOI pixel encoder: one pixel (RGB, or gray in red when color_mode is 0) is taken per cycle
// while full is low and turned into its QOI op bytes (run, index, diff, luma or RGB, alpha fixed
// at 255). The front end registers each pixel with its read of the 64-entry color index,
// classifies it, and then the pixel's byte group (up to five bytes) enters a four-deep queue.
// The back end sends one byte per cycle while pop is high, so sustained input rate is set by the
// byte output: one pixel per cycle while pixels average one byte or less, and a five-byte pixel
// holds the output port until all five are popped. A pixel that only extends a run produces
// no bytes. last_of_item marks the final byte of each pixel; last_pixel flushes a pending run
// and clears all state but the color mode. Reset clears the color index. Depends on qoi_pkg.
module qoi_pixel_encoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_color_mode,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_blue,
    input  logic        i_last_pixel,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_out_byte,
    output logic        o_last_of_item
);
    import qoi_pkg::*;

    t_op  f_op, q_op;
    logic f_push, q_full, q_empty, q_pop;

    qoi_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_color_mode (i_color_mode),
        .push         (push),
        .full         (full),
        .i_red        (i_red),
        .i_green      (i_green),
        .i_blue       (i_blue),
        .i_last_pixel (i_last_pixel),
        .o_op_push    (f_push),
        .o_op         (f_op),
        .i_op_full    (q_full)
    );

    qoi_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  (f_op),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_op),
        .o_empty (q_empty)
    );

    qoi_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_op           (q_op),
        .i_op_empty     (q_empty),
        .o_op_pop       (q_pop),
        .empty          (empty),
        .pop            (pop),
        .o_out_byte     (o_out_byte),
        .o_last_of_item (o_last_of_item)
    );

endmodule

// ----- hw/rtl/qoi_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the QOI pixel encoder, bound to the top level.
// Depends only on the top level's ports.
module qoi_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       full,
    input logic       empty,
    input logic       pop,
    input logic [7:0] o_out_byte,
    input logic       o_last_of_item
);

    // reset leaves no bytes pending
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result side not empty after reset");

    // reset leaves the input side open
    a_reset_open: assert property (@(posedge i_clk) !i_rst_n |=> !full)
        else $error("input side full after reset");

    // the rest of a pixel's byte group is already held in the back end
    a_group_whole: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop && !o_last_of_item) |=> !empty)
        else $error("byte group broken off before its last byte");

    // a waiting byte holds until its transfer
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_out_byte) && $stable(o_last_of_item)))
        else $error("waiting result changed before transfer");

endmodule

bind qoi_pixel_encoder qoi_checker u_qoi_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .full           (full),
    .empty          (empty),
    .pop            (pop),
    .o_out_byte     (o_out_byte),
    .o_last_of_item (o_last_of_item)
);
